// ===== rtl/rgbfx_pkg.sv =====
// Shared types, codes and constants of the RGB LED effect generator.
`timescale 1ns / 1ps

package rgbfx_pkg;

  // Widths
  localparam int TICK_BITS = 32;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int LANE_W    = 16;
  localparam int PROD_W    = 32;
  localparam int RAMP_W    = 14;
  localparam int NUM_LANES = 3;

  // Register indexes (byte address divided by four)
  localparam logic [2:0] REG_RED    = 3'd0;
  localparam logic [2:0] REG_GREEN  = 3'd1;
  localparam logic [2:0] REG_BLUE   = 3'd2;
  localparam logic [2:0] REG_BRIGHT = 3'd3;
  localparam logic [2:0] REG_MODE   = 3'd4;
  localparam logic [2:0] REG_ENABLE = 3'd5;

  // Effect modes
  localparam logic [2:0] MODE_STEADY  = 3'd0;
  localparam logic [2:0] MODE_BLINK   = 3'd1;
  localparam logic [2:0] MODE_FAST    = 3'd2;
  localparam logic [2:0] MODE_BREATHE = 3'd3;
  localparam logic [2:0] MODE_RAINBOW = 3'd4;

  // Timing of the effects, in ticks
  localparam logic [5:0] BLINK_PERIOD   = 6'd50;
  localparam logic [5:0] BLINK_HALF     = 6'd25;
  localparam logic [3:0] FAST_PERIOD    = 4'd10;
  localparam logic [3:0] FAST_HALF      = 4'd5;
  localparam logic [7:0] BREATHE_PERIOD = 8'd150;
  localparam logic [7:0] BREATHE_HALF   = 8'd75;
  localparam logic [7:0] HUE_PERIOD     = 8'd240;
  localparam logic [7:0] HUE_SEG        = 8'd40;

  localparam logic [6:0] BRIGHT_MAX = 7'd100;
  localparam logic [7:0] LEVEL_MAX  = 8'd255;

  // Reciprocals for truncating division by 100, 75 and 40 over the value
  // ranges that occur here (below 25501, 19126 and 9946 respectively).
  localparam logic [LANE_W-1:0] RECIP_100    = 16'd20972;
  localparam int                RECIP_100_SH = 21;
  localparam logic [LANE_W-1:0] RECIP_75     = 16'd27963;
  localparam int                RECIP_75_SH  = 21;
  localparam logic [RAMP_W-1:0] RECIP_40     = 14'd13108;
  localparam int                RECIP_40_SH  = 19;

  // Configuration registers
  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [6:0] brightness_pct;
    logic [2:0] effect_mode;
    logic       led_enable;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_COUNT,
    DP_RAMP,
    DP_RDIV,
    DP_LOAD,
    DP_MULB,
    DP_DIV100,
    DP_MULW,
    DP_DIV75,
    DP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic breathe;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/rgbfx_regs.sv =====
// Configuration register file with its APB-style access port.
`timescale 1ns / 1ps

module rgbfx_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rgbfx_pkg::ADDR_W-1:0] paddr,
  input  logic [rgbfx_pkg::DATA_W-1:0] pwdata,
  output logic [rgbfx_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rgbfx_pkg::cfg_t             cfg_o
);
  import rgbfx_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       wr_en;
  logic [6:0] bri_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign bri_wr  = (pwdata[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[6:0];

  // Register writes; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_RED:    cfg_d.base_red       = pwdata[7:0];
        REG_GREEN:  cfg_d.base_green     = pwdata[7:0];
        REG_BLUE:   cfg_d.base_blue      = pwdata[7:0];
        REG_BRIGHT: cfg_d.brightness_pct = bri_wr;
        REG_MODE:   cfg_d.effect_mode    = pwdata[2:0];
        REG_ENABLE: cfg_d.led_enable     = pwdata[0];
        default:    cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_t'{base_red:       8'd0,
                      base_green:     8'd0,
                      base_blue:      8'd0,
                      brightness_pct: BRIGHT_MAX,
                      effect_mode:    MODE_STEADY,
                      led_enable:     1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back of the stored values.
  always_comb begin
    unique case (reg_idx)
      REG_RED:    prdata = DATA_W'(cfg_q.base_red);
      REG_GREEN:  prdata = DATA_W'(cfg_q.base_green);
      REG_BLUE:   prdata = DATA_W'(cfg_q.base_blue);
      REG_BRIGHT: prdata = DATA_W'(cfg_q.brightness_pct);
      REG_MODE:   prdata = DATA_W'(cfg_q.effect_mode);
      REG_ENABLE: prdata = DATA_W'(cfg_q.led_enable);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rgbfx_datapath.sv =====
// Datapath: tick and phase counters, hue ramp unit, three colour lanes and output register.
`timescale 1ns / 1ps

module rgbfx_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rgbfx_pkg::cfg_t     cfg_i,
  input  rgbfx_pkg::dp_cmd_t  cmd_i,
  output rgbfx_pkg::dp_sts_t  sts_o,
  input  logic                tick_pulse_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [23:0]         out_data_o
);
  import rgbfx_pkg::*;

  logic [TICK_BITS-1:0] tick_count_q, tick_count_d;
  logic [5:0]           ph50_q, ph50_d;
  logic [3:0]           ph10_q, ph10_d;
  logic [7:0]           ph150_q, ph150_d;
  logic [7:0]           ph240_q, ph240_d;
  logic                 advance, wrap;

  logic [2:0]           seg, seg_q;
  logic [5:0]           hue_pos;
  logic [RAMP_W-1:0]    x_q;
  logic [2*RAMP_W-1:0]  ramp_prod;
  logic [7:0]           rq_q, rq_inv;

  logic [6:0]           weight;
  logic [LANE_W-1:0]    opb;
  logic [LANE_W-1:0]    lane_q [NUM_LANES];
  logic [LANE_W-1:0]    lane_d [NUM_LANES];
  logic [PROD_W-1:0]    prod   [NUM_LANES];
  logic [7:0]           load_v [NUM_LANES];

  logic                 show;
  logic                 out_valid_q;
  logic [23:0]          out_data_q;

  // Tick counter and the phases it implies; a wrap of the count restarts every phase.
  assign advance = (cmd_i.op == DP_COUNT) && tick_pulse_i && cfg_i.led_enable &&
                   (cfg_i.effect_mode != MODE_STEADY);
  assign wrap    = (tick_count_q == '1);

  always_comb begin
    tick_count_d = tick_count_q + TICK_BITS'(1);
    ph50_d  = (wrap || ph50_q == BLINK_PERIOD - 6'd1) ? '0 : ph50_q + 6'd1;
    ph10_d  = (wrap || ph10_q == FAST_PERIOD - 4'd1) ? '0 : ph10_q + 4'd1;
    ph150_d = (wrap || ph150_q == BREATHE_PERIOD - 8'd1) ? '0 : ph150_q + 8'd1;
    ph240_d = (wrap || ph240_q == HUE_PERIOD - 8'd1) ? '0 : ph240_q + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      ph50_q       <= '0;
      ph10_q       <= '0;
      ph150_q      <= '0;
      ph240_q      <= '0;
    end else if (advance) begin
      tick_count_q <= tick_count_d;
      ph50_q       <= ph50_d;
      ph10_q       <= ph10_d;
      ph150_q      <= ph150_d;
      ph240_q      <= ph240_d;
    end
  end

  // Hue wheel segment and position within it.
  always_comb begin
    if (ph240_q < HUE_SEG) begin
      seg = 3'd0;
      hue_pos = 6'(ph240_q);
    end else if (ph240_q < 8'(2 * HUE_SEG)) begin
      seg = 3'd1;
      hue_pos = 6'(ph240_q - HUE_SEG);
    end else if (ph240_q < 8'(3 * HUE_SEG)) begin
      seg = 3'd2;
      hue_pos = 6'(ph240_q - 8'(2 * HUE_SEG));
    end else if (ph240_q < 8'(4 * HUE_SEG)) begin
      seg = 3'd3;
      hue_pos = 6'(ph240_q - 8'(3 * HUE_SEG));
    end else if (ph240_q < 8'(5 * HUE_SEG)) begin
      seg = 3'd4;
      hue_pos = 6'(ph240_q - 8'(4 * HUE_SEG));
    end else begin
      seg = 3'd5;
      hue_pos = 6'(ph240_q - 8'(5 * HUE_SEG));
    end
  end

  // Ramp unit: q * 255 first, then the division by 40 in the next cycle.
  assign ramp_prod = (2*RAMP_W)'(x_q) * (2*RAMP_W)'(RECIP_40);
  assign rq_inv    = LEVEL_MAX - rq_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_RAMP) begin
      seg_q <= seg;
      x_q   <= RAMP_W'({hue_pos, 8'd0}) - RAMP_W'(hue_pos);
    end
    if (cmd_i.op == DP_RDIV) begin
      rq_q <= ramp_prod[RECIP_40_SH +: 8];
    end
  end

  // Lane sources: the set colour, or the hue wheel colour in rainbow mode.
  always_comb begin
    load_v[0] = cfg_i.base_red;
    load_v[1] = cfg_i.base_green;
    load_v[2] = cfg_i.base_blue;
    if (cfg_i.effect_mode == MODE_RAINBOW) begin
      case (seg_q)
        3'd0: begin
          load_v[0] = LEVEL_MAX; load_v[1] = rq_q;      load_v[2] = '0;
        end
        3'd1: begin
          load_v[0] = rq_inv;    load_v[1] = LEVEL_MAX; load_v[2] = '0;
        end
        3'd2: begin
          load_v[0] = '0;        load_v[1] = LEVEL_MAX; load_v[2] = rq_q;
        end
        3'd3: begin
          load_v[0] = '0;        load_v[1] = rq_inv;    load_v[2] = LEVEL_MAX;
        end
        3'd4: begin
          load_v[0] = rq_q;      load_v[1] = '0;        load_v[2] = LEVEL_MAX;
        end
        default: begin
          load_v[0] = LEVEL_MAX; load_v[1] = '0;        load_v[2] = rq_inv;
        end
      endcase
    end
  end

  // Triangle weight of the breathing effect.
  assign weight = (ph150_q < BREATHE_HALF) ? 7'(ph150_q) : 7'(BREATHE_PERIOD - ph150_q);

  // Second operand of the lane multipliers.
  always_comb begin
    case (cmd_i.op)
      DP_MULB:   opb = LANE_W'(cfg_i.brightness_pct);
      DP_MULW:   opb = LANE_W'(weight);
      DP_DIV100: opb = RECIP_100;
      DP_DIV75:  opb = RECIP_75;
      default:   opb = '0;
    endcase
  end

  // One multiplier per lane; the division steps keep the upper product bits.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod[i] = PROD_W'(lane_q[i]) * PROD_W'(opb);
      case (cmd_i.op) inside
        DP_LOAD:                lane_d[i] = LANE_W'(load_v[i]);
        DP_MULB, DP_MULW:       lane_d[i] = prod[i][LANE_W-1:0];
        DP_DIV100:              lane_d[i] = LANE_W'(prod[i] >> RECIP_100_SH);
        DP_DIV75:               lane_d[i] = LANE_W'(prod[i] >> RECIP_75_SH);
        default:                lane_d[i] = lane_q[i];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_q[i] <= lane_d[i];
    end
  end

  // Whether the LED is lit in this phase of the effect.
  always_comb begin
    case (cfg_i.effect_mode) inside
      MODE_STEADY, MODE_BREATHE, MODE_RAINBOW: show = 1'b1;
      MODE_BLINK: show = (ph50_q < BLINK_HALF);
      MODE_FAST:  show = (ph10_q < FAST_HALF);
      default:    show = 1'b0;
    endcase
    show = show && cfg_i.led_enable;
  end

  // Output register, loaded only when the previous result has gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_FIN) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_FIN) begin
      out_data_q <= show ? {lane_q[2][7:0], lane_q[1][7:0], lane_q[0][7:0]} : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;
  assign sts_o.breathe    = (cfg_i.effect_mode == MODE_BREATHE);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/rgbfx_ctrl.sv =====
// Controller: sequences the datapath operations for one tick request.
`timescale 1ns / 1ps

module rgbfx_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rgbfx_pkg::dp_sts_t sts_i,
  output rgbfx_pkg::dp_cmd_t cmd_o
);
  import rgbfx_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RAMP   = 4'd1;
  localparam logic [3:0] ST_RDIV   = 4'd2;
  localparam logic [3:0] ST_LOAD   = 4'd3;
  localparam logic [3:0] ST_MULB   = 4'd4;
  localparam logic [3:0] ST_DIV100 = 4'd5;
  localparam logic [3:0] ST_MULW   = 4'd6;
  localparam logic [3:0] ST_DIV75  = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0] state_q, state_d;

  // Next state and the operation issued in each state.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DP_NOP;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_COUNT;
          state_d  = ST_RAMP;
        end
      end
      ST_RAMP: begin
        cmd_o.op = DP_RAMP;
        state_d  = ST_RDIV;
      end
      ST_RDIV: begin
        cmd_o.op = DP_RDIV;
        state_d  = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.op = DP_LOAD;
        state_d  = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.op = DP_MULB;
        state_d  = ST_DIV100;
      end
      ST_DIV100: begin
        cmd_o.op = DP_DIV100;
        state_d  = sts_i.breathe ? ST_MULW : ST_FIN;
      end
      ST_MULW: begin
        cmd_o.op = DP_MULW;
        state_d  = ST_DIV75;
      end
      ST_DIV75: begin
        cmd_o.op = DP_DIV75;
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/rgb_led_effect_generator_core.sv =====
// Each tick request runs the ramp, ramp division, load, brightness multiply, division by
// 100 and result steps, plus a weight multiply and division by 75 in breathe mode. A new
// request is taken only when the last is done, as the steps share the lane multipliers.
// A colour waiting at the output stalls only the last step of the next request.
// Reset clears the tick counter and the configuration; brightness resets to 100.
`timescale 1ns / 1ps

module rgb_led_effect_generator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Tick requests
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [0] tick_pulse, [7:1] zero
  // Colour results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata,  // [7:0] out_red, [15:8] out_green,
                                                     // [23:16] out_blue
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rgbfx_pkg::ADDR_W-1:0] paddr,
  input  logic [rgbfx_pkg::DATA_W-1:0] pwdata,
  output logic [rgbfx_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rgbfx_pkg::*;

  cfg_t    cfg;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rgbfx_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rgbfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  rgbfx_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .tick_pulse_i (s_axis_tdata[0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

  // A request is worked on alone: no second request straight after the first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("tick request accepted while the previous one is in progress");

  // Brightness is held saturated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.brightness_pct <= BRIGHT_MAX)
    else $error("brightness register above its maximum");

  // The result is only loaded when the output register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == DP_FIN) |-> dp_sts.out_free)
    else $error("colour result overwrites one not yet taken");

endmodule

// ===== tb/sv/rgb_led_effect_generator_core_test.sv =====
// Self-checking testbench of the RGB LED effect generator core: ticks in, colours checked.
`timescale 1ns / 1ps

module rgb_led_effect_generator_core_test;
  import rgbfx_pkg::*;

  // Register indexes that decode to no register; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam int unsigned TOTAL_TICKS    = 1050;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned MAX_LINES      = 200;

  // One colour result, red in the lowest byte as on m_axis_tdata.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  // Tracks the effect state, predicts the colour of each tick and checks results.
  class led_colour_tracker;
    logic [7:0]  red_c, green_c, blue_c;
    logic [6:0]  bright;
    logic [2:0]  mode;
    logic        enable;
    logic [31:0] tick_count;
    colour_t     colours_due[$];
    int unsigned fail_count;

    function new();
      red_c      = '0;
      green_c    = '0;
      blue_c     = '0;
      bright     = BRIGHT_MAX;
      mode       = MODE_STEADY;
      enable     = 1'b0;
      tick_count = '0;
      fail_count = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_RED:    red_c = value[7:0];
        REG_GREEN:  green_c = value[7:0];
        REG_BLUE:   blue_c = value[7:0];
        REG_BRIGHT: bright = (value[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : value[6:0];
        REG_MODE:   mode = value[2:0];
        REG_ENABLE: enable = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned scale(int unsigned c);
      return (c * int'(bright)) / 100;
    endfunction

    // Works out the colour that the accepted tick must produce.
    function void note_tick(logic pulse);
      int unsigned s_r, s_g, s_b, t, p, w, r, g, b;
      colour_t     c;
      s_r = scale(red_c);
      s_g = scale(green_c);
      s_b = scale(blue_c);
      if (enable && mode != MODE_STEADY && pulse) tick_count = tick_count + 32'd1;
      t = tick_count;
      r = 0;
      g = 0;
      b = 0;
      if (enable) begin
        case (mode)
          MODE_STEADY: begin
            r = s_r; g = s_g; b = s_b;
          end
          MODE_BLINK: begin
            if ((t / BLINK_HALF) % 2 == 0) begin
              r = s_r; g = s_g; b = s_b;
            end
          end
          MODE_FAST: begin
            if ((t / FAST_HALF) % 2 == 0) begin
              r = s_r; g = s_g; b = s_b;
            end
          end
          MODE_BREATHE: begin
            p = t % BREATHE_PERIOD;
            w = (p < BREATHE_HALF) ? p : BREATHE_PERIOD - p;
            r = (s_r * w) / BREATHE_HALF;
            g = (s_g * w) / BREATHE_HALF;
            b = (s_b * w) / BREATHE_HALF;
          end
          MODE_RAINBOW: begin
            p = t % HUE_PERIOD;
            // Six hue segments, each ramping one component up or down.
            if (p < 40) begin
              r = LEVEL_MAX; g = (p * LEVEL_MAX) / HUE_SEG; b = 0;
            end else if (p < 80) begin
              r = LEVEL_MAX - ((p - 40) * LEVEL_MAX) / HUE_SEG; g = LEVEL_MAX; b = 0;
            end else if (p < 120) begin
              r = 0; g = LEVEL_MAX; b = ((p - 80) * LEVEL_MAX) / HUE_SEG;
            end else if (p < 160) begin
              r = 0; g = LEVEL_MAX - ((p - 120) * LEVEL_MAX) / HUE_SEG; b = LEVEL_MAX;
            end else if (p < 200) begin
              r = ((p - 160) * LEVEL_MAX) / HUE_SEG; g = 0; b = LEVEL_MAX;
            end else begin
              r = LEVEL_MAX; g = 0; b = LEVEL_MAX - ((p - 200) * LEVEL_MAX) / HUE_SEG;
            end
            r = scale(r);
            g = scale(g);
            b = scale(b);
          end
          default: ;
        endcase
      end
      c.red   = r[7:0];
      c.green = g[7:0];
      c.blue  = b[7:0];
      colours_due.push_back(c);
    endfunction

    task report(string msg);
      if (fail_count < MAX_LINES) $display("ERROR: %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_colour(colour_t got);
      colour_t want;
      if (colours_due.size() == 0) begin
        report($sformatf("colour %h arrived with no tick outstanding", got));
      end else begin
        want = colours_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          report($sformatf("colour r/g/b got %0d/%0d/%0d, predicted %0d/%0d/%0d",
                           got.red, got.green, got.blue, want.red, want.green, want.blue));
      end
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [0] tick_pulse, [7:1] zero
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  led_colour_tracker tracker = new();
  int unsigned tx_idle_pct  = 35;
  int unsigned rx_idle_pct  = 71;
  bit          rx_hold_req  = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned stall_cycles = 0;

  rgb_led_effect_generator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Colour receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      rx_hold_req  = 1'b0;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left  = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Observe both handshakes; a tick is noted before the colour of the same edge is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) tracker.note_tick(s_axis_tdata[0]);
      if (m_axis_tvalid && m_axis_tready) tracker.check_colour(colour_t'(m_axis_tdata));
    end
  end

  // Watchdog on cycles without any handshake or register access.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one tick request and wait until it is taken; then maybe idle a while.
  task send_tick(logic pulse);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, pulse};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted colour has been delivered.
  // The first edge lets a request taken at the current edge be noted first.
  task drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.colours_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write over the configuration port, only with the block idle.
  task write_reg(logic [2:0] idx, logic [31:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    bit          pressure_done;
    sent          = 0;
    pressure_done = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset state, extremes, every mode and the odd cases.
    send_tick(1'b1);
    send_tick(1'b0);
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_RED, 32'd255);
    write_reg(REG_GREEN, 32'd255);
    write_reg(REG_BLUE, 32'd255);
    send_tick(1'b1);
    write_reg(REG_BRIGHT, 32'd0);
    send_tick(1'b1);
    // Brightness above range saturates to full.
    write_reg(REG_BRIGHT, 32'd127);
    send_tick(1'b1);
    write_reg(REG_RED, 32'd0);
    write_reg(REG_GREEN, 32'd128);
    write_reg(REG_BLUE, 32'd1);
    write_reg(REG_BRIGHT, 32'd37);
    send_tick(1'b1);
    write_reg(REG_MODE, 32'(MODE_BLINK));
    send_tick(1'b1);
    send_tick(1'b0);
    write_reg(REG_MODE, 32'(MODE_FAST));
    repeat (3) send_tick(1'b1);
    write_reg(REG_MODE, 32'(MODE_BREATHE));
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    write_reg(REG_MODE, 32'(MODE_RAINBOW));
    send_tick(1'b1);
    send_tick(1'b1);
    // Undefined modes still advance the counter but show black.
    write_reg(REG_MODE, 32'd5);
    send_tick(1'b1);
    write_reg(REG_MODE, 32'd6);
    send_tick(1'b1);
    write_reg(REG_MODE, 32'd7);
    send_tick(1'b1);
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
    write_reg(REG_MODE, 32'(MODE_RAINBOW));
    send_tick(1'b1);
    write_reg(REG_ENABLE, 32'd0);
    send_tick(1'b1);
    write_reg(REG_BRIGHT, 32'd100);
    write_reg(REG_MODE, 32'(MODE_STEADY));
    write_reg(REG_ENABLE, 32'd1);
    send_tick(1'b1);
    sent = 22;

    // Random part: segments of ticks, each under a fresh setting.
    while (sent < TOTAL_TICKS) begin
      if (sent < 350) begin
        tx_idle_pct = 35;
        rx_idle_pct = 71;
      end else if (sent < 700) begin
        tx_idle_pct = 71;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if ($urandom_range(1) != 0) begin
        case ($urandom_range(3))
          0:       write_reg(REG_RED, 32'd0);
          1:       write_reg(REG_RED, 32'd255);
          default: write_reg(REG_RED, $urandom_range(255));
        endcase
      end
      if ($urandom_range(1) != 0) begin
        case ($urandom_range(3))
          0:       write_reg(REG_GREEN, 32'd0);
          1:       write_reg(REG_GREEN, 32'd255);
          default: write_reg(REG_GREEN, $urandom_range(255));
        endcase
      end
      if ($urandom_range(1) != 0) begin
        case ($urandom_range(3))
          0:       write_reg(REG_BLUE, 32'd0);
          1:       write_reg(REG_BLUE, 32'd255);
          default: write_reg(REG_BLUE, $urandom_range(255));
        endcase
      end
      if ($urandom_range(1) != 0) begin
        case ($urandom_range(4))
          0:       write_reg(REG_BRIGHT, 32'd0);
          1:       write_reg(REG_BRIGHT, 32'd100);
          2:       write_reg(REG_BRIGHT, $urandom_range(101, 127));
          default: write_reg(REG_BRIGHT, $urandom_range(100));
        endcase
      end
      if ($urandom_range(9) < 8)
        write_reg(REG_MODE, $urandom_range(4));
      else
        write_reg(REG_MODE, $urandom_range(5, 7));
      write_reg(REG_ENABLE, ($urandom_range(9) != 0) ? 32'd1 : 32'd0);
      if ($urandom_range(9) == 0)
        write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
      // Once, starve the output long enough for the input to back up.
      if (!pressure_done && sent >= 750) begin
        rx_hold_req   = 1'b1;
        pressure_done = 1'b1;
      end
      seg_len = $urandom_range(20, 160);
      if (seg_len > TOTAL_TICKS - sent) seg_len = TOTAL_TICKS - sent;
      repeat (seg_len) send_tick($urandom_range(9) != 0);
      sent = sent + seg_len;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (tracker.colours_due.size() != 0)
      tracker.report($sformatf("%0d colours never arrived", tracker.colours_due.size()));
    if (tracker.fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
